// ===== hw/rtl/panel_stop_estop_controller_macros.svh =====
// ----------------------------------------------------------------------------
// panel_stop_estop_controller_macros.svh
// Assertion macros used by the panel stop controller top level.
// ----------------------------------------------------------------------------
`ifndef PANEL_STOP_ESTOP_CONTROLLER_MACROS_SVH
`define PANEL_STOP_ESTOP_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pse assertion failed");

// Next-cycle implication, checked outside reset
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pse assertion failed");

`endif

// ===== hw/rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Types and codes of the panel run/stop controller.
// ----------------------------------------------------------------------------
package pse_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_CHECK = 2'd1;
    localparam logic [1:0] KIND_FORCE = 2'd2;

    // stop reasons
    localparam logic [2:0] REASON_NONE   = 3'd0;
    localparam logic [2:0] REASON_MANUAL = 3'd1;
    localparam logic [2:0] REASON_FULL   = 3'd2;
    localparam logic [2:0] REASON_NOCARD = 3'd3;
    localparam logic [2:0] REASON_ALARM  = 3'd4;
    localparam logic [2:0] REASON_ESTOP  = 3'd5;

    // alarm codes that mean no alarm
    localparam logic [7:0] ALARM_CLEAR = 8'd0;
    localparam logic [7:0] ALARM_NINE  = 8'd9;

    localparam logic [3:0] PRESS_TICKS_RESET = 4'd5;
    localparam logic [3:0] COUNT_MAX         = 4'd15;

    typedef struct packed {
        logic [1:0] kind;
        logic       start_level;
        logic       stop_level;
        logic       estop_level;
        logic [3:0] full_flags;
        logic       card_present;
        logic [7:0] alarm_code;
        logic [3:0] stop_mask;
    } t_in_item;

    typedef struct packed {
        logic       running;
        logic       paused;
        logic       estop_active;
        logic [2:0] reason;
        logic       home_request;
        logic       set_alarm_nine;
        logic       full_changed;
        logic       notice_valid;
        logic [2:0] notice_reason;
    } t_out_item;

    // button status from the debouncers to the controller
    typedef struct packed {
        logic start_press;
        logic stop_press;
        logic start_held;
    } t_press;

endpackage

// ===== hw/rtl/pse_in_stage.sv =====
// ----------------------------------------------------------------------------
// pse_in_stage
// Input register: holds one transaction until the result stage takes it.
// ----------------------------------------------------------------------------
module pse_in_stage
    import pse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // stall only when holding an item that cannot move on
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/pse_debounce.sv =====
// ----------------------------------------------------------------------------
// pse_debounce
// Hold counter for one active-low button, saturating at threshold+1.
// ----------------------------------------------------------------------------
module pse_debounce
    import pse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_level,
    input  logic [3:0] i_thr,
    output logic       o_press,
    output logic       o_held
);

    logic [3:0] r_count;
    logic [3:0] n_count;
    logic [3:0] lim;

    // limit is threshold+1, capped at the counter maximum
    assign lim = (i_thr == COUNT_MAX) ? COUNT_MAX : (i_thr + 4'd1);

    always_comb begin
        n_count = r_count;
        o_press = 1'b0;
        if (i_level) begin
            n_count = '0;
        end else if (r_count < lim) begin
            n_count = r_count + 4'd1;
            o_press = (n_count == i_thr);
        end
    end

    // held flag looks at the count after this tick
    assign o_held = (n_count >= i_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/pse_ctrl.sv =====
// ----------------------------------------------------------------------------
// pse_ctrl
// Run/pause/E-stop state and stop reason, one update per transaction.
// ----------------------------------------------------------------------------
module pse_ctrl
    import pse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_press    i_press,
    output t_out_item o_result
);

    logic       r_run, r_pause, r_estop;
    logic [2:0] r_reason;
    logic [3:0] r_last_full, r_mask;
    logic       n_run, n_pause, n_estop;
    logic [2:0] n_reason;
    logic [3:0] n_last_full, n_mask;
    logic       home, nine, fchg, nvalid;
    logic [2:0] nreason;
    logic       alarm, sp, tp;
    logic       full_hit, check_hit;

    assign alarm = (i_item.alarm_code != ALARM_CLEAR) && (i_item.alarm_code != ALARM_NINE);
    assign sp    = i_press.start_press;
    assign tp    = i_press.stop_press;
    assign full_hit  = (i_item.full_flags & r_mask) != 4'd0;
    assign check_hit = (i_item.full_flags & i_item.stop_mask) != 4'd0;

    // next state for the item in the input register
    always_comb begin
        n_run       = r_run;
        n_pause     = r_pause;
        n_estop     = r_estop;
        n_reason    = r_reason;
        n_last_full = r_last_full;
        n_mask      = r_mask;
        home        = 1'b0;
        nine        = 1'b0;
        fchg        = 1'b0;
        nvalid      = 1'b0;
        nreason     = REASON_NONE;
        case (i_item.kind)
            KIND_TICK: begin
                if (i_item.full_flags != r_last_full) begin
                    n_last_full = i_item.full_flags;
                    fchg        = 1'b1;
                end
                if (i_item.estop_level && !r_estop) begin
                    // E-stop pressed
                    n_estop = 1'b1;
                    n_run   = 1'b0;
                    n_pause = 1'b0;
                    nvalid  = 1'b1;
                    if (alarm) begin
                        n_reason = REASON_ALARM;
                    end else begin
                        n_reason = REASON_ESTOP;
                        nine     = 1'b1;
                    end
                end else if (!i_item.estop_level && r_estop) begin
                    // E-stop released
                    n_estop  = 1'b0;
                    n_run    = 1'b0;
                    n_pause  = 1'b0;
                    nvalid   = 1'b1;
                    n_reason = REASON_ESTOP;
                end else if (r_estop) begin
                    // still latched: nothing
                end else if (r_reason == REASON_ESTOP && !alarm) begin
                    if (sp) begin
                        n_run    = 1'b1;
                        n_pause  = 1'b0;
                        n_reason = REASON_NONE;
                        home     = 1'b1;
                    end
                end else if (r_reason == REASON_ESTOP) begin
                    // alarm after E-stop: start held plus stop press
                    if (i_press.start_held && tp) begin
                        n_run    = 1'b1;
                        n_pause  = 1'b0;
                        n_reason = REASON_NONE;
                        home     = 1'b1;
                    end
                end else if (alarm) begin
                    n_reason = REASON_ALARM;
                    n_run    = 1'b0;
                    n_pause  = 1'b0;
                    if (sp) begin
                        n_run    = 1'b1;
                        n_reason = REASON_NONE;
                        home     = 1'b1;
                    end
                end else if (r_reason == REASON_FULL) begin
                    if (!full_hit) begin
                        if (!i_item.card_present) begin
                            n_reason = REASON_NOCARD;
                            nvalid   = 1'b1;
                            nreason  = REASON_NOCARD;
                        end else begin
                            n_pause  = 1'b0;
                            n_run    = 1'b1;
                            n_reason = REASON_NONE;
                            n_mask   = '0;
                            nvalid   = 1'b1;
                        end
                    end
                end else if (r_reason == REASON_NOCARD) begin
                    if (i_item.card_present) begin
                        if (full_hit) begin
                            n_reason = REASON_FULL;
                            nvalid   = 1'b1;
                            nreason  = REASON_FULL;
                        end else begin
                            n_pause  = 1'b0;
                            n_run    = 1'b1;
                            n_reason = REASON_NONE;
                            n_mask   = '0;
                            nvalid   = 1'b1;
                        end
                    end
                end else if (r_reason == REASON_MANUAL) begin
                    if (sp) begin
                        n_pause  = 1'b0;
                        n_run    = 1'b1;
                        n_reason = REASON_NONE;
                        n_mask   = '0;
                        nvalid   = 1'b1;
                    end
                end else if (!r_pause && tp && !sp) begin
                    n_pause  = 1'b1;
                    n_run    = 1'b0;
                    n_reason = REASON_MANUAL;
                    nvalid   = 1'b1;
                    nreason  = REASON_MANUAL;
                end
            end
            KIND_CHECK: begin
                n_mask = i_item.stop_mask;
                if (check_hit || !i_item.card_present) begin
                    n_pause  = 1'b1;
                    n_run    = 1'b0;
                    n_reason = check_hit ? REASON_FULL : REASON_NOCARD;
                    nvalid   = 1'b1;
                    nreason  = check_hit ? REASON_FULL : REASON_NOCARD;
                end
            end
            KIND_FORCE: begin
                n_mask   = i_item.stop_mask;
                n_pause  = 1'b1;
                n_run    = 1'b0;
                n_reason = REASON_FULL;
                nvalid   = 1'b1;
                nreason  = REASON_FULL;
            end
            default: begin
                // unused kind leaves everything as is
            end
        endcase
    end

    always_comb begin
        o_result.running        = n_run;
        o_result.paused         = n_pause;
        o_result.estop_active   = n_estop;
        o_result.reason         = n_reason;
        o_result.home_request   = home;
        o_result.set_alarm_nine = nine;
        o_result.full_changed   = fchg;
        o_result.notice_valid   = nvalid;
        o_result.notice_reason  = nreason;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b1;
            r_pause     <= 1'b0;
            r_estop     <= 1'b0;
            r_reason    <= REASON_NONE;
            r_last_full <= '0;
            r_mask      <= '0;
        end else if (i_step) begin
            r_run       <= n_run;
            r_pause     <= n_pause;
            r_estop     <= n_estop;
            r_reason    <= n_reason;
            r_last_full <= n_last_full;
            r_mask      <= n_mask;
        end
    end

endmodule

// ===== hw/rtl/panel_stop_estop_controller.sv =====
// ----------------------------------------------------------------------------
// panel_stop_estop_controller
// Machine-panel run/stop controller with button debounce and E-stop handling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one transaction
//   per cycle while o_in_stall is low: a tick with button, E-stop, full, card
//   and alarm levels, a full-or-card stop check, or a forced full stop.
//   Output channel (o_out_valid / i_out_stall / o_out_item) returns exactly one
//   result per transaction, in order: flags, reason and the pulses.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes press_ticks;
//   it is always ready and should be written only while the block is idle.
//   Path: each transaction is held in the input register, then its result
//   is held in the result register. Throughput: one transaction per cycle
//   while the receiver does not stall, set by the combinational state update
//   between the two registers.
//   Reset: running set, all other flags clear, reason none, counters zero,
//   press_ticks 5; both registers empty.
//   When the receiver stalls, the result register holds; one more transaction
//   is taken into the input register, after which o_in_stall rises.
// ----------------------------------------------------------------------------
`include "panel_stop_estop_controller_macros.svh"

module panel_stop_estop_controller
    import pse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    logic      r_out_valid;
    t_out_item r_out_item;
    logic [3:0] r_press_ticks;
    logic      advance, stage_valid, step, tick_step;
    logic [3:0] thr;
    t_in_item  stage_item;
    t_press    press;
    t_out_item result;

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks <= PRESS_TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_press_ticks <= i_cfg_data;
        end
    end

    // zero threshold behaves as one
    assign thr = (r_press_ticks == 4'd0) ? 4'd1 : r_press_ticks;

    assign advance   = !r_out_valid || !i_out_stall;
    assign step      = stage_valid && advance;
    assign tick_step = step && (stage_item.kind == KIND_TICK);

    pse_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    pse_debounce u_start_db (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (tick_step),
        .i_level (stage_item.start_level),
        .i_thr   (thr),
        .o_press (press.start_press),
        .o_held  (press.start_held)
    );

    logic stop_held_unused;
    pse_debounce u_stop_db (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (tick_step),
        .i_level (stage_item.stop_level),
        .i_thr   (thr),
        .o_press (press.stop_press),
        .o_held  (stop_held_unused)
    );

    pse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (stage_item),
        .i_press  (press),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    `PSE_ASSERT_NOW(a_stall_cause, o_in_stall, r_out_valid && i_out_stall)
    `PSE_ASSERT_NOW(a_notice_reason, r_out_valid && (r_out_item.notice_reason != REASON_NONE), r_out_item.notice_valid)
    `PSE_ASSERT_NOW(a_estop_stopped, r_out_valid && r_out_item.estop_active, !r_out_item.running)
    `PSE_ASSERT_NOW(a_nine_estop, r_out_valid && r_out_item.set_alarm_nine, r_out_item.estop_active && (r_out_item.reason == REASON_ESTOP))
    `PSE_ASSERT_NEXT(a_step_result, step, r_out_valid)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the panel run/stop controller.
// A transaction-level model of the controller tracks buttons, E-stop, alarm and
// full/card stops and predicts the status of every transaction; a monitor
// compares each returned status in order. Directed cases come first, then
// random panel activity under several press thresholds, with random gaps
// and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import pse_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT  = 500;
    localparam int         PHASE_ITEMS = 270;
    localparam int         IN_W        = $bits(t_in_item);

    // DUT ports
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data = '0;

    // model state
    logic [3:0] press_ticks_cfg = PRESS_TICKS_RESET;
    logic [3:0] start_hold = '0;
    logic [3:0] stop_hold = '0;
    logic [3:0] last_full_flags = '0;
    logic [3:0] stop_enable = '0;
    logic       run_now = 1'b1;
    logic       pause_now = 1'b0;
    logic       estop_now = 1'b0;
    logic [2:0] reason_now = REASON_NONE;
    t_out_item  predicted_status;

    // checking
    t_out_item  expected_status_q[$];
    int         mismatch_count = 0;
    int         stall_left = 0;
    int         idle_cycles = 0;
    bit         no_idle = 1'b0;

    panel_stop_estop_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------------

    // One debounce step: returns {press, next count}
    function automatic logic [4:0] button_next(input logic [3:0] hold, input logic level,
                                               input logic [3:0] thr);
        logic [3:0] lim;
        lim = (thr == COUNT_MAX) ? COUNT_MAX : thr + 4'd1;
        if (level)
            return 5'd0;
        if (hold < lim)
            return {(hold + 4'd1) == thr, hold + 4'd1};
        return {1'b0, hold};
    endfunction

    function automatic void stop_machine(input logic [2:0] why);
        pause_now = 1'b1;
        run_now = 1'b0;
        reason_now = why;
        predicted_status.notice_valid = 1'b1;
        predicted_status.notice_reason = why;
    endfunction

    function automatic void resume_machine();
        pause_now = 1'b0;
        run_now = 1'b1;
        reason_now = REASON_NONE;
        stop_enable = '0;
        predicted_status.notice_valid = 1'b1;
        predicted_status.notice_reason = REASON_NONE;
    endfunction

    function automatic void request_homing();
        run_now = 1'b1;
        pause_now = 1'b0;
        reason_now = REASON_NONE;
        predicted_status.home_request = 1'b1;
    endfunction

    // Tick transaction, in priority order: E-stop, recovery, alarm, full/card, manual
    function automatic void panel_tick(input t_in_item it);
        logic [3:0] thr;
        logic [4:0] nxt;
        logic       start_press, stop_press, alarm;
        thr = (press_ticks_cfg == 4'd0) ? 4'd1 : press_ticks_cfg;
        nxt = button_next(start_hold, it.start_level, thr);
        start_press = nxt[4];
        start_hold = nxt[3:0];
        nxt = button_next(stop_hold, it.stop_level, thr);
        stop_press = nxt[4];
        stop_hold = nxt[3:0];
        alarm = (it.alarm_code != ALARM_CLEAR) && (it.alarm_code != ALARM_NINE);

        if (it.full_flags != last_full_flags) begin
            last_full_flags = it.full_flags;
            predicted_status.full_changed = 1'b1;
        end

        // E-stop press and release
        if (it.estop_level && !estop_now) begin
            estop_now = 1'b1;
            run_now = 1'b0;
            pause_now = 1'b0;
            predicted_status.notice_valid = 1'b1;
            predicted_status.notice_reason = REASON_NONE;
            if (alarm) begin
                reason_now = REASON_ALARM;
            end else begin
                reason_now = REASON_ESTOP;
                predicted_status.set_alarm_nine = 1'b1;
            end
            return;
        end
        if (!it.estop_level && estop_now) begin
            estop_now = 1'b0;
            run_now = 1'b0;
            pause_now = 1'b0;
            predicted_status.notice_valid = 1'b1;
            predicted_status.notice_reason = REASON_NONE;
            reason_now = REASON_ESTOP;
            return;
        end
        if (estop_now)
            return;

        // recovery after E-stop: start alone, or start held plus stop under alarm
        if (reason_now == REASON_ESTOP) begin
            if (!alarm) begin
                if (start_press)
                    request_homing();
            end else if (start_hold >= thr && stop_press) begin
                request_homing();
            end
            return;
        end

        if (alarm) begin
            reason_now = REASON_ALARM;
            run_now = 1'b0;
            pause_now = 1'b0;
            if (start_press)
                request_homing();
            return;
        end

        // full / no card release
        if (reason_now == REASON_FULL) begin
            if ((it.full_flags & stop_enable) != 4'd0)
                return;
            if (!it.card_present) begin
                reason_now = REASON_NOCARD;
                predicted_status.notice_valid = 1'b1;
                predicted_status.notice_reason = REASON_NOCARD;
                return;
            end
            resume_machine();
            return;
        end
        if (reason_now == REASON_NOCARD) begin
            if (!it.card_present)
                return;
            if ((it.full_flags & stop_enable) != 4'd0) begin
                reason_now = REASON_FULL;
                predicted_status.notice_valid = 1'b1;
                predicted_status.notice_reason = REASON_FULL;
                return;
            end
            resume_machine();
            return;
        end

        // manual pause and resume; an alarm reason without alarm lands here
        if (reason_now == REASON_MANUAL) begin
            if (start_press)
                resume_machine();
            return;
        end
        if (!pause_now && stop_press && !start_press)
            stop_machine(REASON_MANUAL);
    endfunction

    function automatic void predict_panel(input t_in_item it);
        predicted_status = '0;
        case (it.kind)
            KIND_TICK: panel_tick(it);
            KIND_CHECK: begin
                stop_enable = it.stop_mask;
                if ((it.full_flags & it.stop_mask) != 4'd0)
                    stop_machine(REASON_FULL);
                else if (!it.card_present)
                    stop_machine(REASON_NOCARD);
            end
            KIND_FORCE: begin
                stop_enable = it.stop_mask;
                stop_machine(REASON_FULL);
            end
            default: ;
        endcase
        predicted_status.running = run_now;
        predicted_status.paused = pause_now;
        predicted_status.estop_active = estop_now;
        predicted_status.reason = reason_now;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------------
    function automatic string status_text(input t_out_item s);
        return $sformatf("run=%0d pause=%0d estop=%0d reason=%0d home=%0d nine=%0d fchg=%0d nv=%0d nr=%0d",
                         s.running, s.paused, s.estop_active, s.reason, s.home_request,
                         s.set_alarm_nine, s.full_changed, s.notice_valid, s.notice_reason);
    endfunction

    task automatic log_mismatch(input string what, input t_out_item want, input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected %s, got %s", $realtime, what, status_text(want),
                     status_text(got));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status_q.size() == 0) begin
                log_mismatch("unexpected result", '0, o_out_item);
            end else begin
                if (o_out_item !== expected_status_q[0])
                    log_mismatch("result mismatch", expected_status_q[0], o_out_item);
                void'(expected_status_q.pop_front());
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 11);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one transaction after a random gap; valid stays high for back-to-back items
    task automatic send_item(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_panel(it);
        expected_status_q.push_back(predicted_status);
    endtask

    task automatic send_tick(input logic start_pin, input logic stop_btn, input logic estop_pin,
                             input logic [3:0] full, input logic card, input logic [7:0] alarm);
        t_in_item it;
        it = '0;
        it.kind = KIND_TICK;
        it.start_level = start_pin;
        it.stop_level = stop_btn;
        it.estop_level = estop_pin;
        it.full_flags = full;
        it.card_present = card;
        it.alarm_code = alarm;
        it.stop_mask = 4'($urandom_range(0, 15));
        send_item(it);
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [3:0] full,
                                input logic card, input logic [3:0] mask);
        t_in_item it;
        it = '0;
        it.kind = kind;
        it.full_flags = full;
        it.card_present = card;
        it.stop_mask = mask;
        send_item(it);
    endtask

    // Hold off the sender until every result is back, then let the pipe settle
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_press_ticks(input logic [3:0] value);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        press_ticks_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_unused_kind();
        t_in_item it;
        it = '1;
        it.kind = KIND_UNUSED;
        send_item(it);
    endtask

    task automatic test_field_extremes();
        send_tick(1'b1, 1'b1, 1'b0, 4'hF, 1'b1, ALARM_NINE);
    endtask

    // Runs at the reset threshold of five ticks
    task automatic test_manual_pause();
        repeat (5) send_tick(1'b1, 1'b0, 1'b0, 4'hF, 1'b1, ALARM_CLEAR);
        repeat (5) send_tick(1'b0, 1'b1, 1'b0, 4'hF, 1'b1, ALARM_CLEAR);
    endtask

    task automatic test_full_and_card();
        send_request(KIND_CHECK, 4'b1000, 1'b1, 4'b1000);
        send_tick(1'b1, 1'b1, 1'b0, 4'h0, 1'b0, ALARM_CLEAR);
        send_tick(1'b1, 1'b1, 1'b0, 4'h0, 1'b1, ALARM_CLEAR);
        send_request(KIND_FORCE, 4'h0, 1'b0, 4'hF);
    endtask

    task automatic test_estop();
        send_tick(1'b1, 1'b1, 1'b1, 4'h0, 1'b1, ALARM_CLEAR);
        send_tick(1'b1, 1'b1, 1'b0, 4'h0, 1'b1, ALARM_CLEAR);
        repeat (2) send_tick(1'b0, 1'b1, 1'b0, 4'h0, 1'b1, ALARM_CLEAR);
    endtask

    task automatic test_alarm_recovery();
        send_tick(1'b1, 1'b1, 1'b0, 4'h0, 1'b1, 8'd255);
        // alarm reason with the alarm gone falls through to manual handling
        send_tick(1'b1, 1'b1, 1'b0, 4'h0, 1'b1, ALARM_CLEAR);
        send_tick(1'b1, 1'b1, 1'b1, 4'h0, 1'b1, 8'd77);
        send_tick(1'b1, 1'b1, 1'b0, 4'h0, 1'b1, 8'd77);
        repeat (2) send_tick(1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 8'd77);
    endtask

    // Random panel activity: buttons held for runs around the threshold,
    // occasional E-stop, alarms, bin changes, card changes and stop requests
    task automatic test_random_traffic(input logic [3:0] ticks, input int n_items);
        t_in_item   it;
        int         sent, start_left, stop_left, roll;
        logic       start_pin, stop_btn, estop_pin, card_pin;
        logic [3:0] full_pins, thr;
        logic [7:0] alarm_pins;
        if (ticks != press_ticks_cfg)
            write_press_ticks(ticks);
        thr = (ticks == 4'd0) ? 4'd1 : ticks;
        start_pin = 1'b1;
        stop_btn = 1'b1;
        estop_pin = 1'b0;
        card_pin = 1'b1;
        full_pins = '0;
        alarm_pins = ALARM_CLEAR;
        start_left = 0;
        stop_left = 0;
        sent = 0;
        no_idle = 1'b0;
        while (sent < n_items) begin
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 99) == 0)
                wait_for_idle();

            // button runs
            if (start_left == 0) begin
                start_pin = 1'($urandom_range(0, 1));
                start_left = start_pin ? $urandom_range(1, 5) : $urandom_range(1, thr + 3);
            end
            start_left--;
            if (stop_left == 0) begin
                stop_btn = 1'($urandom_range(0, 1));
                stop_left = stop_btn ? $urandom_range(1, 5) : $urandom_range(1, thr + 3);
            end
            stop_left--;

            if (estop_pin)
                estop_pin = ($urandom_range(0, 9) != 0);
            else
                estop_pin = ($urandom_range(0, 59) == 0);

            roll = $urandom_range(0, 99);
            if (alarm_pins == ALARM_CLEAR || alarm_pins == ALARM_NINE) begin
                if (roll < 3)
                    alarm_pins = 8'($urandom_range(1, 255));
                else if (roll < 6)
                    alarm_pins = $urandom_range(0, 1) ? ALARM_NINE : ALARM_CLEAR;
            end else if (roll < 10) begin
                alarm_pins = (roll < 5) ? ALARM_CLEAR : ALARM_NINE;
            end

            if ($urandom_range(0, 11) == 0)
                full_pins = $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(0, 15));
            if ($urandom_range(0, 15) == 0)
                card_pin = !card_pin;

            it = '0;
            it.kind = KIND_TICK;
            it.start_level = start_pin;
            it.stop_level = stop_btn;
            it.estop_level = estop_pin;
            it.full_flags = full_pins;
            it.card_present = card_pin;
            it.alarm_code = alarm_pins;
            it.stop_mask = 4'($urandom_range(0, 15));

            roll = $urandom_range(0, 99);
            if (roll < 7) begin
                it.kind = KIND_CHECK;
            end else if (roll < 11) begin
                it.kind = KIND_FORCE;
            end else if (roll < 13) begin
                it = t_in_item'(IN_W'($urandom));
                it.kind = KIND_UNUSED;
            end
            send_item(it);
            if (it.kind != KIND_UNUSED)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unused_kind();
        test_field_extremes();
        test_manual_pause();
        test_full_and_card();
        write_press_ticks(4'd2);
        test_estop();
        test_alarm_recovery();

        test_random_traffic(4'd0, PHASE_ITEMS);
        test_random_traffic(4'd15, PHASE_ITEMS);
        test_random_traffic(4'd1, PHASE_ITEMS);
        test_random_traffic(4'd14, PHASE_ITEMS);
        test_random_traffic(4'($urandom_range(2, 13)), PHASE_ITEMS);
        test_random_traffic(PRESS_TICKS_RESET, PHASE_ITEMS);

        wait_for_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pse_pkg.sv
hw/rtl/pse_in_stage.sv
hw/rtl/pse_debounce.sv
hw/rtl/pse_ctrl.sv
hw/rtl/panel_stop_estop_controller.sv
bench/testbench.sv
